// File: src/xrd_pkg.sv
// ----------------------------------------------------------------------------
// XML reference decoder package
// Shared types and constants for the front parser, the entry queue and the
// byte serializer.
// ----------------------------------------------------------------------------
package xrd_pkg;

    localparam int HOLD_DEPTH  = 11;
    localparam int ENTRY_BYTES = HOLD_DEPTH + 1;
    localparam int CNT_W       = $clog2(ENTRY_BYTES + 1);
    localparam int CODE_W      = 21;

    typedef enum logic {
        KIND_FLUSH = 1'b0,
        KIND_CHAR  = 1'b1
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t                      kind;
        logic [ENTRY_BYTES-1:0][7:0]      data;
        logic [CNT_W-1:0]                 count;
        logic [CODE_W-1:0]                code;
        logic                             eot;
    } entry_t;

endpackage

// File: src/xml_reference_decoder.sv
// ----------------------------------------------------------------------------
// XML reference decoder
// Decodes named and numeric character references in a byte stream into
// UTF-8, passing all other bytes through.
// ----------------------------------------------------------------------------
// The s_ channel takes one text byte per handshake, with s_in_last marking the
// last byte of a run. The m_ channel gives one output byte per item, with
// m_out_last_of_item on the last byte caused by an input byte and
// m_out_end_of_text on the last byte of a run.
// The parser accepts one input byte per cycle while its two-entry queue has
// room. The serializer gives one output byte per cycle while m_ready is high;
// a plain byte accepted by the parser passes through the queue and the
// registered output stage to m_. A decoded code point leaves as 1 to 4 bytes,
// and a failed reference as up to 12 bytes; input is taken on meanwhile until
// the queue is full.
// A held byte of an open reference produces no output until the reference
// is decided or the run ends.
// When m_ready is low, the output byte holds and the queue fills, after which
// s_ready drops. Reset empties the queue and the output stage and drops any
// open reference.
// ----------------------------------------------------------------------------
module xml_reference_decoder #(
    parameter int MAX_DIGITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_last_of_item,
    output logic        m_out_end_of_text
);
    import xrd_pkg::*;

    logic    accept;
    logic    push;
    entry_t  push_entry;
    logic    pop;
    logic    full;
    logic    head_valid;
    entry_t  head;

    assign s_ready = !full;
    assign accept  = s_valid && s_ready;

    xrd_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_in_byte),
        .in_last (s_in_last),
        .push    (push),
        .entry   (push_entry)
    );

    xrd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    xrd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .head_valid         (head_valid),
        .head               (head),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_out_last_of_item (m_out_last_of_item),
        .m_out_end_of_text  (m_out_end_of_text)
    );

endmodule

// File: src/xrd_front.sv
// ----------------------------------------------------------------------------
// XML reference decoder front
// Parses one byte per cycle while the queue has room, holds the bytes of an
// open reference and turns each byte into at most one queue entry: a run of
// literal bytes or a decoded code point.
// ----------------------------------------------------------------------------
module xrd_front #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output xrd_pkg::entry_t     entry
);
    import xrd_pkg::*;

    localparam int ACC_W   = 4 * MAX_DIGITS;
    localparam int TALLY_W = $clog2(MAX_DIGITS + 1);
    localparam int HC_W    = $clog2(HOLD_DEPTH + 1);
    localparam int NAMES   = 5;
    localparam int NAME_MAX = 5;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;

    localparam logic [31:0] CODE_MAX   = 32'h0010_FFFF;
    localparam logic [31:0] SURR_FIRST = 32'h0000_D800;
    localparam logic [31:0] SURR_LAST  = 32'h0000_DFFF;

    localparam logic [7:0] NAME_TEXT [NAMES][NAME_MAX] = '{
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B}
    };
    localparam logic [HC_W-1:0] NAME_LEN [NAMES] = '{
        HC_W'(4), HC_W'(3), HC_W'(3), HC_W'(5), HC_W'(5)
    };
    localparam logic [7:0] NAME_VALUE [NAMES] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_NAME   = 4'b0010,
        PH_HASH   = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_FAIL,
        ACT_DONE
    } action_t;

    phase_t               phase_reg, phase_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;
    logic                 hex_reg, hex_next;
    logic [HC_W-1:0]      hc_reg, hc_next;
    logic [7:0]           held_reg [HOLD_DEPTH];

    logic                 held_we;
    logic [HC_W-1:0]      held_wa;

    logic [ENTRY_BYTES-1:0][7:0] cmb;
    logic [HC_W-1:0]      pos;
    logic                 name_done;
    logic                 name_prefix;
    logic [7:0]           name_val;
    logic                 pm;

    logic                 is_semi;
    logic                 dig_ok;
    logic [3:0]           dig_val;
    logic [31:0]          acc_ext;
    logic                 code_bad;
    logic [ACC_W-1:0]     acc_cand;

    action_t              act;
    phase_t               hold_phase;
    logic                 hold_hex;
    logic [ACC_W-1:0]     hold_acc;
    logic [TALLY_W-1:0]   hold_tally;
    logic [CODE_W-1:0]    done_code;

    always_comb begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            cmb[i] = (HC_W'(i) < hc_reg) ? held_reg[i] : in_byte;
        end
        cmb[HOLD_DEPTH] = in_byte;
    end

    always_comb begin
        pos         = hc_reg - HC_W'(1);
        name_done   = 1'b0;
        name_prefix = 1'b0;
        name_val    = 8'h00;
        pm          = 1'b0;
        for (int k = NAMES - 1; k >= 0; k--) begin
            pm = (pos < NAME_LEN[k]);
            for (int j = 0; j < NAME_MAX; j++) begin
                if (HC_W'(j) < pos && held_reg[j + 1] != NAME_TEXT[k][j]) begin
                    pm = 1'b0;
                end
                if (HC_W'(j) == pos && in_byte != NAME_TEXT[k][j]) begin
                    pm = 1'b0;
                end
            end
            if (pm && (pos + HC_W'(1) == NAME_LEN[k])) begin
                name_done = 1'b1;
                name_val  = NAME_VALUE[k];
            end else if (pm) begin
                name_prefix = 1'b1;
            end
        end
    end

    always_comb begin
        is_semi = (in_byte == CH_SEMI);
        dig_ok  = 1'b0;
        dig_val = 4'd0;
        if (in_byte >= CH_0 && in_byte <= CH_9) begin
            dig_ok  = 1'b1;
            dig_val = 4'(in_byte - CH_0);
        end else if (hex_reg && in_byte >= CH_A_LO && in_byte <= CH_F_LO) begin
            dig_ok  = 1'b1;
            dig_val = 4'(in_byte - CH_A_LO) + 4'd10;
        end else if (hex_reg && in_byte >= CH_A_UP && in_byte <= CH_F_UP) begin
            dig_ok  = 1'b1;
            dig_val = 4'(in_byte - CH_A_UP) + 4'd10;
        end
        acc_ext  = 32'(acc_reg);
        code_bad = (tally_reg == '0) || (acc_ext == 32'd0) || (acc_ext > CODE_MAX) ||
                   (acc_ext >= SURR_FIRST && acc_ext <= SURR_LAST);
        if (hex_reg) begin
            acc_cand = (acc_reg << 4) | ACC_W'(dig_val);
        end else begin
            acc_cand = (acc_reg << 3) + (acc_reg << 1) + ACC_W'(dig_val);
        end
    end

    always_comb begin
        act        = ACT_FAIL;
        hold_phase = phase_reg;
        hold_hex   = hex_reg;
        hold_acc   = acc_reg;
        hold_tally = tally_reg;
        done_code  = acc_ext[CODE_W-1:0];
        unique case (phase_reg)
            PH_NAME: begin
                if (hc_reg == HC_W'(1) && in_byte == CH_HASH) begin
                    act        = ACT_HOLD;
                    hold_phase = PH_HASH;
                end else if (name_done) begin
                    act       = ACT_DONE;
                    done_code = CODE_W'(name_val);
                end else if (name_prefix) begin
                    act = ACT_HOLD;
                end
            end
            PH_HASH, PH_DIGITS: begin
                if (phase_reg == PH_HASH && (in_byte == CH_X_LO || in_byte == CH_X_UP)) begin
                    act        = ACT_HOLD;
                    hold_phase = PH_DIGITS;
                    hold_hex   = 1'b1;
                end else if (is_semi) begin
                    act = code_bad ? ACT_FAIL : ACT_DONE;
                end else if (tally_reg >= TALLY_W'(MAX_DIGITS) || !dig_ok) begin
                    act = ACT_FAIL;
                end else begin
                    act        = ACT_HOLD;
                    hold_phase = PH_DIGITS;
                    hold_acc   = acc_cand;
                    hold_tally = tally_reg + TALLY_W'(1);
                end
            end
            default: begin
                act = ACT_FAIL;
            end
        endcase
        if (act == ACT_HOLD && hc_reg >= HC_W'(HOLD_DEPTH)) begin
            act = ACT_FAIL;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        tally_next  = tally_reg;
        hex_next    = hex_reg;
        hc_next     = hc_reg;
        held_we     = 1'b0;
        held_wa     = hc_reg;
        push        = 1'b0;
        entry.kind  = KIND_FLUSH;
        entry.data  = cmb;
        entry.count = CNT_W'(hc_reg) + CNT_W'(1);
        entry.code  = done_code;
        entry.eot   = in_last;
        if (accept) begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            tally_next = '0;
            hex_next   = 1'b0;
            hc_next    = '0;
            unique case (act)
                ACT_HOLD: begin
                    if (in_last) begin
                        push = 1'b1;
                    end else begin
                        phase_next = hold_phase;
                        acc_next   = hold_acc;
                        tally_next = hold_tally;
                        hex_next   = hold_hex;
                        hc_next    = hc_reg + HC_W'(1);
                        held_we    = 1'b1;
                    end
                end
                ACT_DONE: begin
                    push       = 1'b1;
                    entry.kind = KIND_CHAR;
                end
                default: begin
                    if (in_byte == CH_AMP && !in_last) begin
                        entry.count = CNT_W'(hc_reg);
                        push        = (hc_reg != '0);
                        phase_next  = PH_NAME;
                        hc_next     = HC_W'(1);
                        held_we     = 1'b1;
                        held_wa     = '0;
                    end else begin
                        push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            tally_reg <= '0;
            hex_reg   <= 1'b0;
            hc_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            tally_reg <= tally_next;
            hex_reg   <= hex_next;
            hc_reg    <= hc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_reg[held_wa] <= in_byte;
        end
    end

endmodule

// File: src/xrd_queue.sv
// ----------------------------------------------------------------------------
// XML reference decoder entry queue
// Two-entry queue between the parser and the serializer.
// ----------------------------------------------------------------------------
module xrd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  xrd_pkg::entry_t     push_entry,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output xrd_pkg::entry_t     head
);
    import xrd_pkg::*;

    entry_t      mem_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = ~wp_reg;
        end
        if (pop) begin
            rp_next = ~rp_reg;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_entry;
        end
    end

endmodule

// File: src/xrd_back.sv
// ----------------------------------------------------------------------------
// XML reference decoder serializer
// Walks the head queue entry one output byte per cycle, unless a low m_ready
// holds the output, encoding decoded code points as UTF-8, into a registered output stage.
// ----------------------------------------------------------------------------
module xrd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  xrd_pkg::entry_t     head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_out_last_of_item,
    output logic                m_out_end_of_text
);
    import xrd_pkg::*;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               valid_reg, valid_next;
    logic [7:0]         byte_reg, byte_next;
    logic               lit_reg, lit_next;
    logic               eot_reg, eot_next;

    logic [CODE_W-1:0]  code;
    logic [2:0]         ulen;
    logic [7:0]         lead;
    logic [7:0]         t0, t1, t2;
    logic [7:0]         ubyte;
    logic [CNT_W-1:0]   len;
    logic [7:0]         cur_byte;
    logic               is_final;
    logic               out_free;

    always_comb begin
        code = head.code;
        t0   = UTF8_CONT | {2'b00, code[5:0]};
        t1   = UTF8_CONT | {2'b00, code[11:6]};
        t2   = UTF8_CONT | {2'b00, code[17:12]};
        if (code < CODE_W'(32'h80)) begin
            ulen = 3'd1;
            lead = code[7:0];
        end else if (code < CODE_W'(32'h800)) begin
            ulen = 3'd2;
            lead = UTF8_LEAD2 | {3'b000, code[10:6]};
        end else if (code < CODE_W'(32'h10000)) begin
            ulen = 3'd3;
            lead = UTF8_LEAD3 | {4'b0000, code[15:12]};
        end else begin
            ulen = 3'd4;
            lead = UTF8_LEAD4 | {5'b00000, code[20:18]};
        end
        if (idx_reg == '0) begin
            ubyte = lead;
        end else if (CNT_W'(ulen) - idx_reg == CNT_W'(3)) begin
            ubyte = t2;
        end else if (CNT_W'(ulen) - idx_reg == CNT_W'(2)) begin
            ubyte = t1;
        end else begin
            ubyte = t0;
        end
        if (head.kind == KIND_CHAR) begin
            len      = CNT_W'(ulen);
            cur_byte = ubyte;
        end else begin
            len      = head.count;
            cur_byte = head.data[idx_reg];
        end
        is_final = (idx_reg == len - CNT_W'(1));
    end

    assign out_free = !valid_reg || m_ready;
    assign pop      = head_valid && out_free && is_final;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        lit_next   = lit_reg;
        eot_next   = eot_reg;
        if (head_valid && out_free) begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            lit_next   = is_final;
            eot_next   = is_final && head.eot;
            idx_next   = is_final ? '0 : idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        lit_reg  <= lit_next;
        eot_reg  <= eot_next;
    end

    assign m_valid            = valid_reg;
    assign m_out_byte         = byte_reg;
    assign m_out_last_of_item = lit_reg;
    assign m_out_end_of_text  = eot_reg;

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// XML reference decoder testbench
// Drives text runs into the decoder through the s_ channel while the m_ side
// stalls at random. A built-in model of reference decoding predicts every
// output byte, and each accepted output item is checked field by field.
// Directed runs come first. Random runs of plain bytes, named references,
// numeric references and broken references follow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIGITS   = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 30;
    localparam int TOTAL_ITEMS  = 360;
    localparam int QUIET_ITEMS  = 60;

    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LOW_M  = 8'h6D;

    typedef enum logic [1:0] {
        SCAN_TEXT,
        SCAN_NAME,
        SCAN_HASH,
        SCAN_DIGITS
    } scan_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       item_end;
        logic       text_end;
    } decoded_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last_of_item;
    logic       m_out_end_of_text;

    string      entity_names [5] = '{"amp;", "lt;", "gt;", "quot;", "apos;"};
    logic [7:0] entity_chars [5] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

    scan_state_t scan_state = SCAN_TEXT;
    logic [31:0] code_point = '0;
    int unsigned digit_count = 0;
    logic        hex_digits = 1'b0;
    logic [7:0]  held_text [xrd_pkg::HOLD_DEPTH];
    int unsigned held_len = 0;
    logic [7:0]  step_bytes [$];

    decoded_byte_t expected_bytes [$];
    text_byte_t    text_queue [$];

    int unsigned items_queued = 0;
    int unsigned items_sent = 0;
    int unsigned inputs_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;
    int unsigned decoded_refs = 0;
    int unsigned literal_refs = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    logic        idling = 1'b1;

    xml_reference_decoder #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_in_byte(s_in_byte),
        .s_in_last(s_in_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_byte(m_out_byte),
        .m_out_last_of_item(m_out_last_of_item),
        .m_out_end_of_text(m_out_end_of_text)
    );

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    function automatic void drop_reference();
        scan_state = SCAN_TEXT;
        code_point = '0;
        digit_count = 0;
        hex_digits = 1'b0;
        held_len = 0;
    endfunction

    function automatic bit hold_byte(logic [7:0] b);
        if (held_len >= xrd_pkg::HOLD_DEPTH) begin
            return 1'b0;
        end
        held_text[held_len] = b;
        held_len++;
        return 1'b1;
    endfunction

    function automatic void release_held();
        for (int i = 0; i < held_len; i++) begin
            step_bytes.push_back(held_text[i]);
        end
        drop_reference();
    endfunction

    function automatic void plain_byte(logic [7:0] b);
        if (b == CH_AMP) begin
            held_text[0] = b;
            held_len = 1;
            scan_state = SCAN_NAME;
        end else begin
            step_bytes.push_back(b);
        end
    endfunction

    // A broken reference goes out as it came in, and the byte that broke it
    // is then treated as fresh text.
    function automatic void abandon_reference(logic [7:0] b);
        literal_refs++;
        release_held();
        plain_byte(b);
    endfunction

    function automatic void put_utf8(logic [31:0] c);
        if (c < 32'h80) begin
            step_bytes.push_back(c[7:0]);
        end else if (c < 32'h800) begin
            step_bytes.push_back({3'b110, c[10:6]});
            step_bytes.push_back({2'b10, c[5:0]});
        end else if (c < 32'h10000) begin
            step_bytes.push_back({4'b1110, c[15:12]});
            step_bytes.push_back({2'b10, c[11:6]});
            step_bytes.push_back({2'b10, c[5:0]});
        end else begin
            step_bytes.push_back({5'b11110, c[20:18]});
            step_bytes.push_back({2'b10, c[17:12]});
            step_bytes.push_back({2'b10, c[11:6]});
            step_bytes.push_back({2'b10, c[5:0]});
        end
    endfunction

    function automatic void name_byte(logic [7:0] b);
        int unsigned pos;
        bit          partial;
        bit          same;
        pos = held_len - 1;
        partial = 1'b0;
        for (int k = 0; k < 5; k++) begin
            if (pos < entity_names[k].len() && entity_names[k][pos] == b) begin
                same = 1'b1;
                for (int i = 0; i < pos; i++) begin
                    if (held_text[i + 1] != entity_names[k][i]) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    if (pos + 1 == entity_names[k].len()) begin
                        drop_reference();
                        decoded_refs++;
                        step_bytes.push_back(entity_chars[k]);
                        return;
                    end
                    partial = 1'b1;
                end
            end
        end
        if (partial && hold_byte(b)) begin
            return;
        end
        abandon_reference(b);
    endfunction

    function automatic void digit_byte(logic [7:0] b);
        logic [31:0] v;
        logic        ok;
        if (b == CH_SEMI) begin
            if (digit_count == 0 || code_point == 0 || code_point > 32'h10FFFF ||
                (code_point >= 32'hD800 && code_point <= 32'hDFFF)) begin
                abandon_reference(b);
            end else begin
                v = code_point;
                drop_reference();
                decoded_refs++;
                put_utf8(v);
            end
            return;
        end
        ok = 1'b1;
        v = '0;
        if (digit_count >= MAX_DIGITS) begin
            ok = 1'b0;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            v = 32'(b - CH_ZERO);
        end else if (hex_digits && b >= CH_LOW_A && b <= CH_LOW_F) begin
            v = 32'(b - CH_LOW_A) + 32'd10;
        end else if (hex_digits && b >= CH_UP_A && b <= CH_UP_F) begin
            v = 32'(b - CH_UP_A) + 32'd10;
        end else begin
            ok = 1'b0;
        end
        if (ok && hold_byte(b)) begin
            code_point = code_point * (hex_digits ? 32'd16 : 32'd10) + v;
            digit_count++;
        end else begin
            abandon_reference(b);
        end
    endfunction

    function automatic void decode_text_byte(logic [7:0] b, logic last);
        decoded_byte_t res;
        int            n;
        step_bytes.delete();
        case (scan_state)
            SCAN_NAME: begin
                if (held_len == 1 && b == CH_HASH) begin
                    if (hold_byte(b)) begin
                        scan_state = SCAN_HASH;
                    end else begin
                        abandon_reference(b);
                    end
                end else begin
                    name_byte(b);
                end
            end
            SCAN_HASH: begin
                if (b == CH_LOW_X || b == CH_UP_X) begin
                    if (hold_byte(b)) begin
                        hex_digits = 1'b1;
                        scan_state = SCAN_DIGITS;
                    end else begin
                        abandon_reference(b);
                    end
                end else begin
                    hex_digits = 1'b0;
                    scan_state = SCAN_DIGITS;
                    digit_byte(b);
                end
            end
            SCAN_DIGITS: begin
                digit_byte(b);
            end
            default: begin
                drop_reference();
                plain_byte(b);
            end
        endcase
        if (last) begin
            if (held_len != 0) begin
                literal_refs++;
            end
            release_held();
        end
        n = step_bytes.size();
        for (int i = 0; i < n; i++) begin
            res.data = step_bytes[i];
            res.item_end = (i == n - 1);
            res.text_end = last && (i == n - 1);
            expected_bytes.push_back(res);
        end
    endfunction

    function automatic void log_mismatch(decoded_byte_t want, decoded_byte_t got, bit orphan);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (orphan) begin
                $display("ERROR output %0d: %02h last_of_item=%0b end_of_text=%0b, none expected",
                         results_checked, got.data, got.item_end, got.text_end);
            end else begin
                $display("ERROR output %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                         results_checked, want.data, want.item_end, want.text_end,
                         got.data, got.item_end, got.text_end);
            end
        end
    endfunction

    always @(posedge aclk) begin : check_outputs
        decoded_byte_t got;
        decoded_byte_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_checked++;
                got.data = m_out_byte;
                got.item_end = m_out_last_of_item;
                got.text_end = m_out_end_of_text;
                if (expected_bytes.size() == 0) begin
                    log_mismatch(got, got, 1'b1);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.data !== want.data || got.item_end !== want.item_end ||
                        got.text_end !== want.text_end) begin
                        log_mismatch(want, got, 1'b0);
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_text_byte(s_in_byte, s_in_last);
                inputs_accepted++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles without a handshake", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin : drive_text
        text_byte_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || inputs_accepted == items_sent) begin
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 7);
                s_valid <= 1'b0;
            end else if (text_queue.size() != 0) begin
                next_item = text_queue.pop_front();
                s_in_byte <= next_item.data;
                s_in_last <= next_item.last;
                s_valid <= 1'b1;
                items_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void queue_byte(logic [7:0] b, logic last);
        text_byte_t item;
        item.data = b;
        item.last = last;
        text_queue.push_back(item);
        items_queued++;
    endfunction

    function automatic logic run_ends();
        return $urandom_range(1, 12) == 1;
    endfunction

    function automatic void queue_text(string s, bit may_end);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i], may_end && run_ends());
        end
    endfunction

    function automatic logic [7:0] stray_byte();
        if ($urandom_range(0, 3) == 0) begin
            return CH_AMP;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 9))
            0: return $urandom_range(1, 32'h7F);
            1: return $urandom_range(32'h80, 32'h7FF);
            2: return $urandom_range(32'h800, 32'hFFFF);
            3: return $urandom_range(32'h10000, 32'h10FFFF);
            4: return $urandom_range(32'hD7FF, 32'hE000);
            5: return 32'h0;
            6: return $urandom_range(32'h110000, 32'hFFFFFF);
            7: return $urandom();
            8: begin
                case ($urandom_range(0, 5))
                    0: return 32'h7F;
                    1: return 32'h80;
                    2: return 32'h7FF;
                    3: return 32'h800;
                    4: return 32'hFFFF;
                    default: return 32'h10FFFF;
                endcase
            end
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    function automatic void queue_numeric(bit hex);
        string       digits_text;
        logic [31:0] cp;
        logic [7:0]  ch;
        int          pad;
        cp = pick_code();
        digits_text = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (pad) begin
            digits_text = {"0", digits_text};
        end
        queue_text("&#", 1'b1);
        if (hex) begin
            queue_byte($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X, run_ends());
        end
        for (int i = 0; i < digits_text.len(); i++) begin
            ch = digits_text[i];
            if (ch >= CH_LOW_A && ch <= CH_LOW_F && $urandom_range(0, 1) == 1) begin
                ch = ch - 8'h20;
            end
            queue_byte(ch, run_ends());
        end
        if ($urandom_range(0, 7) == 0) begin
            queue_byte(stray_byte(), run_ends());
        end else begin
            queue_byte(CH_SEMI, run_ends());
        end
    endfunction

    function automatic void queue_fragment();
        string name;
        int    cut;
        name = entity_names[$urandom_range(0, 4)];
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                queue_byte(8'($urandom_range(0, 255)), run_ends());
            end
            3, 4: begin
                queue_text({"&", name}, 1'b1);
            end
            5: begin
                cut = $urandom_range(0, name.len() - 1);
                queue_byte(CH_AMP, run_ends());
                for (int i = 0; i < cut; i++) begin
                    queue_byte(name[i], run_ends());
                end
                queue_byte(stray_byte(), run_ends());
            end
            6, 7: begin
                queue_numeric(1'b0);
            end
            8, 9: begin
                queue_numeric(1'b1);
            end
            10: begin
                queue_text("&#", 1'b1);
                queue_byte(stray_byte(), run_ends());
            end
            default: begin
                queue_text($urandom_range(0, 1) ? "&#x" : "&#X", 1'b1);
                queue_byte(stray_byte(), run_ends());
            end
        endcase
    endfunction

    task automatic wait_for_drain();
        do begin
            @(negedge aclk);
        end while (inputs_accepted != items_queued || expected_bytes.size() != 0);
        @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_text("&lt;", 1'b0);
        queue_text("&#x1F600;", 1'b0);
        queue_text("&#233;", 1'b0);
        queue_text("&#;", 1'b0);
        queue_text("&a", 1'b0);
        queue_byte(CH_LOW_M, 1'b1);

        // Hold the next items back until the decoder has emptied out.
        wait_for_drain();

        while (items_queued < TOTAL_ITEMS) begin
            queue_fragment();
        end
        while (inputs_accepted + QUIET_ITEMS < items_queued) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        idling = 1'b0;

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("%0d text bytes in, %0d output bytes checked", inputs_accepted,
                 results_checked);
        $display("%0d references decoded, %0d passed through as literal text", decoded_refs,
                 literal_refs);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
